// ===== hw/rtl/awg_pkg.sv =====
`default_nettype none

package awg_pkg;

	localparam int TABLE_SIZE   = 2048;
	localparam int MAX_PARTIALS = 64;

	localparam int IDX_W  = $clog2(TABLE_SIZE);
	localparam int QTR_W  = IDX_W - 2;
	localparam int MODE_W = 3;
	localparam int NP_W   = 7;
	localparam int CFG_W  = 7;
	localparam int OUT_W  = 24;
	localparam int WPT_W  = $clog2(MAX_PARTIALS);
	localparam int PC_W   = $clog2(MAX_PARTIALS + 3);
	localparam int ACC_W  = 38;
	localparam int RND_SH = 10;

	localparam logic [2:0] MODE_SAW    = 3'd0;
	localparam logic [2:0] MODE_SOFT   = 3'd1;
	localparam logic [2:0] MODE_PULSE  = 3'd2;
	localparam logic [2:0] MODE_SQUARE = 3'd3;
	localparam logic [2:0] MODE_ODD_SQ = 3'd4;
	localparam logic [2:0] MODE_TRI    = 3'd5;
	localparam logic [2:0] MODE_RAMP   = 3'd6;
	localparam logic [2:0] MODE_NONE   = 3'd7;

	localparam logic REG_WAVE_MODE    = 1'b0;
	localparam logic REG_NUM_PARTIALS = 1'b1;

	localparam logic [63:0] Q30_ONE = 64'd1073741824;
	localparam logic [63:0] SIN_C1  = 64'd1686629713;
	localparam logic [63:0] SIN_C3  = 64'd693598668;
	localparam logic [63:0] SIN_C5  = 64'd85569306;
	localparam logic [63:0] SIN_C7  = 64'd5026996;
	localparam logic [63:0] SIN_C9  = 64'd172272;
	localparam logic [63:0] SIN_C11 = 64'd3864;

	localparam logic [63:0] RAMP_DIV  = 64'(TABLE_SIZE - 1);
	localparam int          RAMP_SH   = 42;
	localparam logic [31:0] RAMP_M    = 32'(((64'd1 << RAMP_SH) + RAMP_DIV - 64'd1) / RAMP_DIV);
	localparam logic [31:0] RAMP_BIAS = 32'(RAMP_DIV / 64'd2);

	localparam logic signed [OUT_W-1:0] OUT_MAX = 24'sh7FFFFF;
	localparam logic signed [OUT_W-1:0] OUT_MIN = 24'sh800000;

	function automatic logic [30:0] sin_mag(input logic [QTR_W:0] k);
		logic [63:0] u;
		logic [63:0] v;
		logic [63:0] acc;
		logic [63:0] mag;
		u   = 64'(k) << (30 - QTR_W);
		v   = (u * u) >> 30;
		acc = SIN_C9 - ((v * SIN_C11) >> 30);
		acc = SIN_C7 - ((v * acc) >> 30);
		acc = SIN_C5 - ((v * acc) >> 30);
		acc = SIN_C3 - ((v * acc) >> 30);
		acc = SIN_C1 - ((v * acc) >> 30);
		mag = (u * acc) >> 30;
		if (mag > Q30_ONE) begin
			mag = Q30_ONE;
		end
		return mag[30:0];
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/awg_req_if.sv =====
`default_nettype none

interface awg_req_if;
	logic                       valid;
	logic                       ready;
	logic [awg_pkg::IDX_W-1:0]  sample_index;

	modport source (output valid, output sample_index, input ready);
	modport sink   (input valid, input sample_index, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/awg_rsp_if.sv =====
`default_nettype none

interface awg_rsp_if;
	logic                             valid;
	logic                             ready;
	logic signed [awg_pkg::OUT_W-1:0] wave_value;
	logic [awg_pkg::IDX_W-1:0]        index_out;

	modport source (output valid, output wave_value, output index_out, input ready);
	modport sink   (input valid, input wave_value, input index_out, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/additive_wavetable_generator.sv =====
// channel   dir   handshake          payload
// req       in    valid / ready      sample_index [10:0]
// rsp       out   valid / ready      wave_value [23:0] signed Q3.20, index_out [10:0]
// cfg       in    cfg_wr_en          cfg_index [0:0], cfg_data [6:0]
//
// One product enters the shared 32x32 multiplier per cycle. P = products issued: num_partials
// capped at 64 (odd partials only in the odd modes), 1 for the ramp, 0 for the unused mode.
// Products pass through the s1 and s2 registers into the accumulator; a request holds req.ready
// low until its result is registered, and req.ready returns in the same cycle as that result.
// The output register frees the engine: the next request is taken while a result waits,
// then holds in its final state until that result is taken.
// arst_n clears the sequencer, valid flags and registers (wave_mode 0, num_partials 16).
`default_nettype none

module additive_wavetable_generator (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wr_en,
	input  wire logic [0:0]                 cfg_index,
	input  wire logic [awg_pkg::CFG_W-1:0]  cfg_data,
	awg_req_if.sink                         req,
	awg_rsp_if.source                       rsp
);

	localparam int IDX_W = awg_pkg::IDX_W;
	localparam int QTR_W = awg_pkg::QTR_W;
	localparam int KW    = QTR_W + 1;
	localparam int HALF  = 1 << (QTR_W - 1);
	localparam int ACC_W = awg_pkg::ACC_W;
	localparam int RND_W = ACC_W - awg_pkg::RND_SH;
	localparam int PC_W  = awg_pkg::PC_W;
	localparam int NP_W  = awg_pkg::NP_W;
	localparam int WPT_W = awg_pkg::WPT_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	localparam logic [30:0] SIN_TOP = awg_pkg::sin_mag(KW'(1 << QTR_W));

	logic [2:0]                       wave_mode_q;
	logic [NP_W-1:0]                  num_partials_q;
	logic [1:0]                       state_q;
	logic [IDX_W-1:0]                 idx_q;
	logic [IDX_W-1:0]                 ph_q;
	logic [IDX_W-1:0]                 step_q;
	logic [PC_W-1:0]                  p_q;
	logic signed [ACC_W-1:0]          acc_q;
	logic                             v_s1;
	logic [31:0]                      mag_s1;
	logic [31:0]                      w_s1;
	logic                             neg_s1;
	logic                             ramp_s1;
	logic                             v_s2;
	logic [31:0]                      term_s2;
	logic                             neg_s2;
	logic                             ramp_s2;
	logic                             rsp_vld_q;
	logic signed [awg_pkg::OUT_W-1:0] value_q;
	logic [IDX_W-1:0]                 idx_out_q;

	logic [30:0]             w1_tab [awg_pkg::MAX_PARTIALS];
	logic [30:0]             w2_tab [awg_pkg::MAX_PARTIALS];
	logic [30:0]             sin_lo [HALF];
	logic [30:0]             sin_hi [HALF];

	logic                    accept_c;
	logic                    odd_c;
	logic [NP_W-1:0]         np_cap_c;
	logic [NP_W-1:0]         lim_c;
	logic                    issue_c;
	logic [WPT_W-1:0]        pidx_c;
	logic [KW-1:0]           kk_c;
	logic [30:0]             sin_c;
	logic [30:0]             wt_c;
	logic [IDX_W+1:0]        rnum_c;
	logic [IDX_W+1:0]        rabs_c;
	logic [31:0]             rx_c;
	logic [63:0]             prod_c;
	logic signed [ACC_W-1:0] ext_c;
	logic signed [ACC_W-1:0] biased_c;
	logic signed [RND_W-1:0] rnd_c;
	logic signed [awg_pkg::OUT_W-1:0] sat_c;
	logic                    out_free_c;

	for (genvar g = 0; g < awg_pkg::MAX_PARTIALS; g++) begin : g_wt
		localparam logic [30:0] W1 = 31'(awg_pkg::Q30_ONE / 64'(g + 1));
		localparam logic [30:0] W2 = 31'(awg_pkg::Q30_ONE / 64'((g + 1) * (g + 1)));
		assign w1_tab[g] = W1;
		assign w2_tab[g] = W2;
	end

	for (genvar g = 0; g < HALF; g++) begin : g_sin
		localparam logic [30:0] SL = awg_pkg::sin_mag(KW'(g));
		localparam logic [30:0] SH = awg_pkg::sin_mag(KW'(g + HALF));
		assign sin_lo[g] = SL;
		assign sin_hi[g] = SH;
	end

	assign req.ready  = (state_q == ST_IDLE);
	assign accept_c   = req.valid && req.ready;
	assign out_free_c = !rsp_vld_q || rsp.ready;

	assign odd_c = (wave_mode_q == awg_pkg::MODE_SQUARE) ||
	               (wave_mode_q == awg_pkg::MODE_ODD_SQ) ||
	               (wave_mode_q == awg_pkg::MODE_TRI);
	assign np_cap_c = (num_partials_q > NP_W'(awg_pkg::MAX_PARTIALS)) ?
	                  NP_W'(awg_pkg::MAX_PARTIALS) : num_partials_q;

	always_comb begin
		unique case (wave_mode_q)
			awg_pkg::MODE_RAMP: lim_c = NP_W'(1);
			awg_pkg::MODE_NONE: lim_c = '0;
			default:            lim_c = np_cap_c;
		endcase
	end

	assign issue_c = (state_q == ST_RUN) && (NP_W'(p_q) <= lim_c) && (p_q <= PC_W'(lim_c));
	assign pidx_c  = WPT_W'(p_q - PC_W'(1));

	assign kk_c  = ph_q[QTR_W] ? (KW'(1 << QTR_W) - KW'(ph_q[QTR_W-1:0]))
	                           : KW'(ph_q[QTR_W-1:0]);
	assign sin_c = kk_c[QTR_W] ? SIN_TOP :
	               kk_c[QTR_W-1] ? sin_hi[kk_c[QTR_W-2:0]] : sin_lo[kk_c[QTR_W-2:0]];

	always_comb begin
		unique case (wave_mode_q)
			awg_pkg::MODE_SAW, awg_pkg::MODE_SQUARE: wt_c = w1_tab[pidx_c];
			awg_pkg::MODE_PULSE: wt_c = w1_tab[WPT_W'(np_cap_c - NP_W'(1))];
			awg_pkg::MODE_SOFT, awg_pkg::MODE_ODD_SQ, awg_pkg::MODE_TRI: wt_c = w2_tab[pidx_c];
			default: wt_c = '0;
		endcase
	end

	assign rnum_c = (IDX_W+2)'(awg_pkg::RAMP_DIV) - {1'b0, idx_q, 1'b0};
	assign rabs_c = rnum_c[IDX_W+1] ? ((IDX_W+2)'(0) - rnum_c) : rnum_c;
	assign rx_c   = (32'(rabs_c[IDX_W-1:0]) << 20) + awg_pkg::RAMP_BIAS;

	assign prod_c = 64'(mag_s1) * 64'(w_s1);

	assign ext_c    = ramp_s2 ? (ACC_W'(term_s2) << awg_pkg::RND_SH) : ACC_W'(term_s2);
	assign biased_c = acc_q + ACC_W'(1 << (awg_pkg::RND_SH - 1));
	assign rnd_c    = RND_W'(biased_c >>> awg_pkg::RND_SH);

	always_comb begin
		priority if (rnd_c > RND_W'(awg_pkg::OUT_MAX)) begin
			sat_c = awg_pkg::OUT_MAX;
		end else if (rnd_c < RND_W'(awg_pkg::OUT_MIN)) begin
			sat_c = awg_pkg::OUT_MIN;
		end else begin
			sat_c = rnd_c[awg_pkg::OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_mode_q    <= awg_pkg::MODE_SAW;
			num_partials_q <= NP_W'(16);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				awg_pkg::REG_WAVE_MODE:    wave_mode_q    <= cfg_data[2:0];
				awg_pkg::REG_NUM_PARTIALS: num_partials_q <= cfg_data[NP_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			v_s1 <= issue_c;
			v_s2 <= v_s1;
			if (state_q == ST_FIN && out_free_c) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept_c) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (!issue_c && !v_s1 && !v_s2) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free_c) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept_c) begin
			idx_q  <= req.sample_index;
			ph_q   <= req.sample_index;
			step_q <= odd_c ? {req.sample_index[IDX_W-2:0], 1'b0} : req.sample_index;
			p_q    <= PC_W'(1);
			acc_q  <= '0;
		end else begin
			if (issue_c) begin
				ph_q <= ph_q + step_q;
				p_q  <= p_q + (odd_c ? PC_W'(2) : PC_W'(1));
			end
			if (v_s2) begin
				acc_q <= neg_s2 ? (acc_q - ext_c) : (acc_q + ext_c);
			end
		end
		if (issue_c) begin
			ramp_s1 <= (wave_mode_q == awg_pkg::MODE_RAMP);
			if (wave_mode_q == awg_pkg::MODE_RAMP) begin
				mag_s1 <= rx_c;
				w_s1   <= awg_pkg::RAMP_M;
				neg_s1 <= rnum_c[IDX_W+1];
			end else begin
				mag_s1 <= 32'(sin_c);
				w_s1   <= 32'(wt_c);
				neg_s1 <= ph_q[IDX_W-1] ^ ((wave_mode_q == awg_pkg::MODE_TRI) && p_q[1]);
			end
		end
		term_s2 <= ramp_s1 ? 32'(prod_c >> awg_pkg::RAMP_SH) : 32'(prod_c >> 30);
		neg_s2  <= neg_s1;
		ramp_s2 <= ramp_s1;
		if (state_q == ST_FIN && out_free_c) begin
			value_q   <= sat_c;
			idx_out_q <= idx_q;
		end
	end

	assign rsp.valid      = rsp_vld_q;
	assign rsp.wave_value = value_q;
	assign rsp.index_out  = idx_out_q;

	a_pipe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_RUN) |-> (!v_s1 && !v_s2))
		else $error("multiplier pipeline busy outside run state");

	a_part_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (p_q <= PC_W'(awg_pkg::MAX_PARTIALS + 2)))
		else $error("partial counter overran");

	a_ramp_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && wave_mode_q == awg_pkg::MODE_RAMP) |-> (p_q <= PC_W'(2)))
		else $error("ramp issued more than one product");

	a_fin_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> (!issue_c && $past(!v_s2)))
		else $error("result taken before accumulator settled");

endmodule

`default_nettype wire
